FILE: rtl/core/tac_pkg.sv
// Shared types and constants for the touchscreen averaging and calibration block.
`default_nettype none

package tac_pkg;

  // Running sum width of one axis run
  localparam int SUM_W = 16;

  // Configuration register indexes
  typedef enum logic [7:0] {
    REG_X_MIN = 8'd0,
    REG_X_MAX = 8'd1,
    REG_Y_MIN = 8'd2,
    REG_Y_MAX = 8'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_EMIT
  } tac_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/tac_div.sv
// Shared bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tac_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] step_cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             q_bit;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh  = {rem, quot[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    q_bit   = (rem_sh >= {1'b0, den_r});
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        step_cnt <= step_cnt - 1'b1;
        if (step_cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in from the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], q_bit};
      rem  <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/touch_average_and_calibrate.sv
// Touchscreen sample averaging and calibration to pixel coordinates.
// Samples arrive as beats on s_*: SAMPLES_PER_AXIS X readings, then as many Y
// readings. A sample that does not close a run leaves the input ready for the
// next one. At a run end the 16-bit sum goes through a reciprocal multiply that
// gives the exact truncated average. The Y run end then maps both axes on the
// shared serial divider, (avg - min) * size / (max - min) truncated toward
// zero and clamped, first X and then Y, and the input is not ready again until
// the result is loaded. The quotient is NUM_W bits wide, with
// NUM_W = ADC_BITS + clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT) + 1),
// and the divider gives one quotient bit per cycle. One result beat on m_*
// carries both coordinates and waits in an output register until taken; a
// result still waiting holds the next Y run end in its emit step. Calibration
// is written through cfg_*, and the user must do so only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module touch_average_and_calibrate
  import tac_pkg::*;
#(
  parameter int SAMPLES_PER_AXIS = 10,
  parameter int SCREEN_WIDTH     = 320,
  parameter int SCREEN_HEIGHT    = 240,
  parameter int ADC_BITS         = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Sample stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [15:0]         s_tdata,   // [11:0] adc_sample
  // Result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata,   // [8:0] pos_x, [16:9] pos_y
  // Calibration writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_addr,
  input  wire logic [ADC_BITS-1:0] cfg_data
);

  localparam int SZ_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SZ_W   = $clog2(SZ_MAX + 1);
  localparam int PROD_W = ADC_BITS + SZ_W;
  localparam int NUM_W  = PROD_W;
  localparam int CNT_W  = $clog2(SAMPLES_PER_AXIS + 1);
  localparam logic [SUM_W-1:0] ADC_MASK = SUM_W'((32'd1 << ADC_BITS) - 32'd1);
  // Reciprocal of the run length, exact for every 16-bit sum
  localparam int AVG_SH     = SUM_W + $clog2(SAMPLES_PER_AXIS);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = AVG_SH + SUM_W + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SH) + SAMPLES_PER_AXIS - 1) / SAMPLES_PER_AXIS);

  tac_state_t state, state_next;

  // Calibration registers
  logic [ADC_BITS-1:0] x_cal_min, x_cal_max, y_cal_min, y_cal_max;

  // Run accumulation
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sample_masked;
  logic [SUM_W-1:0] sum_inc;
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] count_inc;
  logic             run_end;
  logic             measuring_y;
  logic [ADC_BITS-1:0] held_x_average;
  logic [ADC_BITS-1:0] y_average;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [ADC_BITS-1:0]   run_average;

  // Mapping datapath
  logic                axis_y;
  logic [ADC_BITS-1:0] avg_sel, lo_sel, hi_sel;
  logic [SZ_W-1:0]     size_sel;
  logic [ADC_BITS:0]   diff, diff_neg, span, span_neg;
  logic [ADC_BITS-1:0] diff_mag, span_mag;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    map_prod;
  logic [ADC_BITS-1:0] map_den;
  logic                map_neg;
  logic                map_zero;
  logic [NUM_W-1:0]    lim;
  logic [NUM_W-1:0]    coord;
  logic [8:0]          pos_x;
  logic [7:0]          pos_y;

  // Divider hookup
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [ADC_BITS-1:0] div_den;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;

  logic emit_load;

  tac_div #(
    .NUM_W (NUM_W),
    .DEN_W (ADC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Accept every calibration write at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cal_min <= '0;
      x_cal_max <= ADC_BITS'(4095);
      y_cal_min <= '0;
      y_cal_max <= ADC_BITS'(4095);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_X_MIN: x_cal_min <= cfg_data;
        REG_X_MAX: x_cal_max <= cfg_data;
        REG_Y_MIN: y_cal_min <= cfg_data;
        REG_Y_MAX: y_cal_max <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Sample accumulation terms
  always_comb begin
    sample_masked = {4'b0000, s_tdata[11:0]} & ADC_MASK;
    sum_inc       = sample_sum + sample_masked;
    count_inc     = sample_count + 1'b1;
    run_end       = (count_inc == CNT_W'(SAMPLES_PER_AXIS));
  end

  // Average of the closed run: multiply by the reciprocal and drop the fraction
  always_comb begin
    avg_prod    = AVG_PROD_W'(sample_sum) * AVG_PROD_W'(AVG_RECIP);
    run_average = avg_prod[AVG_SH +: ADC_BITS];
  end

  // Select the axis being mapped and form its offset and span
  always_comb begin
    avg_sel  = axis_y ? y_average : held_x_average;
    lo_sel   = axis_y ? y_cal_min : x_cal_min;
    hi_sel   = axis_y ? y_cal_max : x_cal_max;
    size_sel = axis_y ? SZ_W'(SCREEN_HEIGHT) : SZ_W'(SCREEN_WIDTH);
    lim      = axis_y ? NUM_W'(SCREEN_HEIGHT - 1) : NUM_W'(SCREEN_WIDTH - 1);
    diff     = {1'b0, avg_sel} - {1'b0, lo_sel};
    span     = {1'b0, hi_sel} - {1'b0, lo_sel};
    diff_neg = -diff;
    span_neg = -span;
    diff_mag = diff[ADC_BITS] ? diff_neg[ADC_BITS-1:0] : diff[ADC_BITS-1:0];
    span_mag = span[ADC_BITS] ? span_neg[ADC_BITS-1:0] : span[ADC_BITS-1:0];
    prod     = PROD_W'(diff_mag) * PROD_W'(size_sel);
  end

  // Clamp the quotient; opposite signs or an empty span give zero
  always_comb begin
    if (map_zero || map_neg) begin
      coord = '0;
    end else if (div_quot > lim) begin
      coord = lim;
    end else begin
      coord = div_quot;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && run_end) state_next = ST_AVG;
      end
      ST_AVG:    state_next = measuring_y ? ST_MUL : ST_IDLE;
      ST_MUL:    state_next = ST_MAP_GO;
      ST_MAP_GO: state_next = ST_MAP_WAIT;
      ST_MAP_WAIT: begin
        if (div_done) state_next = axis_y ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    div_num   = map_prod;
    div_den   = map_den;
    emit_load = 1'b0;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_MAP_GO: div_start = 1'b1;
      ST_EMIT:   emit_load = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Run control: sum, count and axis flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      measuring_y  <= 1'b0;
      axis_y       <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sample_sum   <= sum_inc;
        sample_count <= run_end ? '0 : count_inc;
      end
      if (state == ST_AVG) begin
        sample_sum  <= '0;
        measuring_y <= !measuring_y;
        axis_y      <= 1'b0;
      end
      if (state == ST_MAP_WAIT && div_done) begin
        axis_y <= 1'b1;
      end
    end
  end

  // Hold averages, mapping operands and coordinates
  always_ff @(posedge clk) begin
    if (state == ST_AVG) begin
      if (measuring_y) begin
        y_average <= run_average;
      end else begin
        held_x_average <= run_average;
      end
    end
    if (state == ST_MUL) begin
      map_prod <= NUM_W'(prod);
      map_den  <= span_mag;
      map_neg  <= diff[ADC_BITS] ^ span[ADC_BITS];
      map_zero <= (span == '0);
    end
    if (state == ST_MAP_WAIT && div_done) begin
      if (axis_y) begin
        pos_y <= coord[7:0];
      end else begin
        pos_x <= coord[8:0];
      end
    end
  end

  // Output register: load the result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {7'b0000000, pos_y, pos_x};
    end
  end

  // The divider reports completion only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MAP_WAIT))
    else $error("divider done outside a wait state");

  // The run count never reaches the run length
  assert property (@(posedge clk) disable iff (rst)
    sample_count < CNT_W'(SAMPLES_PER_AXIS))
    else $error("sample count out of range");

  // A result loaded in the emit state shows up on the output next cycle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not presented after emit");

endmodule

`default_nettype wire

FILE: tb/tac_position_checker.sv
// Checker for the touchscreen block: tracks calibration and samples, predicts and compares positions.
`timescale 1ns / 100ps

module tac_position_checker
  import tac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,   // [11:0] adc_sample
  // Result stream
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [23:0] m_tdata,   // [8:0] pos_x, [16:9] pos_y
  // Calibration writes
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_addr,
  input  wire logic [11:0] cfg_data,
  // Status toward the testbench top
  output int               mismatches,
  output int               results_due
);

  localparam int SAMPLES_PER_AXIS = 10;
  localparam int SCREEN_WIDTH     = 320;
  localparam int SCREEN_HEIGHT    = 240;

  typedef struct packed {
    logic [8:0] pos_x;
    logic [7:0] pos_y;
  } touch_pos_t;

  // Calibration copy
  logic [11:0] x_lo, x_hi, y_lo, y_hi;

  // Run tracking
  logic [15:0] run_sum;
  int          run_len;
  logic        on_y;
  logic [11:0] x_avg;

  touch_pos_t  pos_due[$];
  int          mismatch_total = 0;

  // Map one average to pixels: signed quotient truncated toward zero, then clamped
  function automatic int scale_axis(input logic [11:0] avg, input logic [11:0] lo,
                                    input logic [11:0] hi, input int size);
    int span;
    int q;
    span = int'(hi) - int'(lo);
    if (span == 0) return 0;
    q = ((int'(avg) - int'(lo)) * size) / span;
    if (q > size - 1) q = size - 1;
    else if (q < 0) q = 0;
    return q;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t tac_position_checker: %s", $time, what);
    mismatch_total++;
  endtask

  always @(posedge clk) begin : track
    logic [11:0] avg;
    touch_pos_t  got;
    touch_pos_t  want;
    if (rst) begin
      x_lo    = '0;
      x_hi    = 12'hFFF;
      y_lo    = '0;
      y_hi    = 12'hFFF;
      run_sum = '0;
      run_len = 0;
      on_y    = 1'b0;
      x_avg   = '0;
      pos_due.delete();
    end else begin
      // Compare a result beat with the oldest pending position
      if (m_tvalid && m_tready) begin
        got.pos_x = m_tdata[8:0];
        got.pos_y = m_tdata[16:9];
        if (pos_due.size() == 0) begin
          report_mismatch($sformatf("result beat x=%0d y=%0d with no position pending",
                                    got.pos_x, got.pos_y));
        end else begin
          want = pos_due.pop_front();
          if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
          if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
        end
      end

      // Track calibration; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_X_MIN: x_lo = cfg_data;
          REG_X_MAX: x_hi = cfg_data;
          REG_Y_MIN: y_lo = cfg_data;
          REG_Y_MAX: y_hi = cfg_data;
          default: ;
        endcase
      end

      // Accumulate a sample beat; close the run after the last one
      if (s_tvalid && s_tready) begin
        run_sum = run_sum + 16'(s_tdata[11:0]);
        run_len++;
        if (run_len == SAMPLES_PER_AXIS) begin
          avg     = 12'(run_sum / SAMPLES_PER_AXIS);
          run_sum = '0;
          run_len = 0;
          if (!on_y) begin
            x_avg = avg;
            on_y  = 1'b1;
          end else begin
            on_y       = 1'b0;
            want.pos_x = 9'(scale_axis(x_avg, x_lo, x_hi, SCREEN_WIDTH));
            want.pos_y = 8'(scale_axis(avg, y_lo, y_hi, SCREEN_HEIGHT));
            pos_due.push_back(want);
          end
        end
      end
    end
    mismatches  <= mismatch_total;
    results_due <= pos_due.size();
  end

endmodule

FILE: tb/tb_touch_average_and_calibrate.sv
// Testbench top for the touchscreen block: sample and calibration stimulus, watchdog, verdict.
`timescale 1ns / 100ps

module tb_touch_average_and_calibrate
  import tac_pkg::*;
();

  localparam int          SAMPLES_PER_AXIS = 10;
  localparam int          ADC_MAX          = 4095;
  localparam int          PHASES           = 10;
  localparam int          FRAMES_PER_PHASE = 7;
  // Longest internal pass is a run average plus the mapping of both axes
  localparam int          SETTLE_CYCLES    = 150;
  localparam int          HOLD_CYCLES      = 600;
  localparam int          IDLE_LIMIT       = 5000;
  localparam logic [7:0]  FIRST_UNUSED_REG = 8'd4;
  localparam logic [7:0]  MAX_REG_CODE     = 8'hFF;

  typedef enum {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_CADENCE} sink_pace_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // [11:0] adc_sample
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;          // [8:0] pos_x, [16:9] pos_y
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_addr  = '0;
  logic [11:0] cfg_data  = '0;

  int          mismatches;
  int          results_due;
  logic        hold_request = 1'b0;
  int          burst_left   = 0;
  logic [11:0] cal_shadow [4];

  always #5 clk = ~clk;

  touch_average_and_calibrate i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  tac_position_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Offer one sample beat; drop valid after the closing beat, or for a gap when the burst runs out
  task automatic put_sample(input logic [11:0] level, input bit closing);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, level};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (closing) begin
      s_tvalid <= 1'b0;
    end else if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
  endtask

  // Send an X run and a Y run, each noise or aimed at a level from the calibration ends, random or a rail
  task automatic send_frame(input bit closing);
    logic [11:0] lo;
    logic [11:0] hi;
    int          target;
    int          spread;
    int          level;
    bit          noisy;
    for (int axis = 0; axis < 2; axis++) begin
      lo     = cal_shadow[2 * axis];
      hi     = cal_shadow[2 * axis + 1];
      noisy  = 1'b0;
      target = 0;
      case ($urandom_range(0, 5))
        0: noisy = 1'b1;
        1: target = lo;
        2: target = hi;
        3: target = (int'(lo) + int'(hi)) / 2;
        4: target = $urandom_range(0, ADC_MAX);
        default: target = $urandom_range(0, 1) ? ADC_MAX : 0;
      endcase
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 3;
        2: spread = 40;
        default: spread = 400;
      endcase
      for (int n = 0; n < SAMPLES_PER_AXIS; n++) begin
        if (noisy) begin
          level = $urandom_range(0, ADC_MAX);
        end else begin
          level = target + int'($urandom_range(0, 2 * spread)) - spread;
          if (level < 0) level = 0;
          else if (level > ADC_MAX) level = ADC_MAX;
        end
        put_sample(12'(level), closing && axis == 1 && n == SAMPLES_PER_AXIS - 1);
      end
    end
  endtask

  // Write one calibration register; valid stays high for a following write
  task automatic write_reg(input logic [7:0] addr, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (addr < FIRST_UNUSED_REG) cal_shadow[addr[1:0]] = value;
  endtask

  // Wait for every pending position, then for the block to finish any run in flight
  task automatic settle();
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed frame, then calibration phases with random frames
  initial begin : stimulus
    logic [11:0] value;
    cal_shadow = '{12'h000, 12'hFFF, 12'h000, 12'hFFF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-scale X clamps to the right edge, zero Y lands on the top row
    for (int n = 0; n < 2 * SAMPLES_PER_AXIS; n++)
      put_sample(n < SAMPLES_PER_AXIS ? 12'hFFF : 12'h000, n == 2 * SAMPLES_PER_AXIS - 1);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        // Full range on both axes, plus a write to an unknown index
        0: begin
          write_reg(REG_X_MIN, 12'h000);
          write_reg(REG_X_MAX, 12'hFFF);
          write_reg(REG_Y_MIN, 12'h000);
          write_reg(REG_Y_MAX, 12'hFFF);
          write_reg(FIRST_UNUSED_REG, 12'(int'($urandom_range(0, ADC_MAX))));
        end
        // Equal ends on X, reversed ends on Y
        1: begin
          write_reg(REG_X_MIN, 12'd2048);
          write_reg(REG_X_MAX, 12'd2048);
          write_reg(REG_Y_MIN, 12'hFFF);
          write_reg(REG_Y_MAX, 12'h000);
        end
        // Reversed ends on X, equal ends on Y
        2: begin
          write_reg(REG_X_MIN, 12'hFFF);
          write_reg(REG_X_MAX, 12'h000);
          write_reg(REG_Y_MIN, 12'h000);
          write_reg(REG_Y_MAX, 12'h000);
        end
        // Narrow window: many averages fall outside it; plus a write to an unknown index
        3: begin
          write_reg(REG_X_MIN, 12'd1000);
          write_reg(REG_X_MAX, 12'd3000);
          write_reg(MAX_REG_CODE, 12'hFFF);
          write_reg(REG_Y_MIN, 12'd500);
          write_reg(REG_Y_MAX, 12'd3500);
        end
        default: begin
          for (int r = 0; r < 4; r++) begin
            if ($urandom_range(0, 3) == 0)
              write_reg(8'($urandom_range(int'(FIRST_UNUSED_REG), int'(MAX_REG_CODE))),
                        12'(int'($urandom_range(0, ADC_MAX))));
            case ($urandom_range(0, 3))
              0: value = 12'h000;
              1: value = 12'hFFF;
              default: value = 12'(int'($urandom_range(0, ADC_MAX)));
            endcase
            write_reg(cfg_reg_t'(r), value);
          end
        end
      endcase
      cfg_valid <= 1'b0;
      if (phase == 2) hold_request <= 1'b1;
      for (int f = 0; f < FRAMES_PER_PHASE; f++)
        send_frame(f == FRAMES_PER_PHASE - 1);
    end

    settle();
    if (mismatches == 0)
      $display("tb_touch_average_and_calibrate: done, clean");
    else
      $display("tb_touch_average_and_calibrate: done, errors");
    $finish;
  end

  // Result sink: change pace at random, hold off once for a long stretch
  initial begin : result_sink
    sink_pace_t pace;
    int         span_left;
    bit         held;
    pace      = SINK_OPEN;
    span_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span_left == 0) begin
        pace      = sink_pace_t'($urandom_range(0, 3));
        span_left = $urandom_range(16, 200);
      end
      span_left--;
      case (pace)
        SINK_OPEN:   m_tready <= 1'b1;
        SINK_HALF:   m_tready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:     m_tready <= (span_left % 3 != 0);
      endcase
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_touch_average_and_calibrate: done, errors");
    $finish;
  end

endmodule
